// ----- hdl/svm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package svm_pkg;

    typedef logic [1:0] req_t;

    localparam req_t REQ_LOAD    = 2'd0;
    localparam req_t REQ_TRIGGER = 2'd1;
    localparam req_t REQ_TICK    = 2'd2;
    localparam req_t REQ_FADEALL = 2'd3;

    localparam int ATTACK_FRAMES = 16;
    localparam int FADE_SHIFT    = 6;
    localparam logic [34:0] GAIN_DIV = 35'd8258175;
    // Reciprocal of the gain divisor scaled by 2^44, for a multiply-and-correct quotient.
    localparam logic [22:0] GAIN_RECIP = 23'((64'd1 << 44) / 64'(GAIN_DIV));

    typedef struct packed {
        logic       load;
        logic [6:0] velocity;
        logic [7:0] pad_gain;
        logic [7:0] master_volume;
    } gain_req_t;

    // Pitch ratio 2^(n/12) in Q16 for n = -12 .. 12, indexed by n + 12.
    function automatic logic [17:0] pitch_ratio(input logic [4:0] idx);
        logic [17:0] r;
        begin
            case (idx)
                5'd0:  r = 18'd32768;
                5'd1:  r = 18'd34716;
                5'd2:  r = 18'd36781;
                5'd3:  r = 18'd38968;
                5'd4:  r = 18'd41285;
                5'd5:  r = 18'd43740;
                5'd6:  r = 18'd46341;
                5'd7:  r = 18'd49097;
                5'd8:  r = 18'd52016;
                5'd9:  r = 18'd55109;
                5'd10: r = 18'd58386;
                5'd11: r = 18'd61858;
                5'd12: r = 18'd65536;
                5'd13: r = 18'd69433;
                5'd14: r = 18'd73562;
                5'd15: r = 18'd77936;
                5'd16: r = 18'd82570;
                5'd17: r = 18'd87480;
                5'd18: r = 18'd92682;
                5'd19: r = 18'd98193;
                5'd20: r = 18'd104032;
                5'd21: r = 18'd110218;
                5'd22: r = 18'd116772;
                5'd23: r = 18'd123715;
                5'd24: r = 18'd131072;
                default: r = 18'd65536;
            endcase
            return r;
        end
    endfunction

endpackage
`default_nettype wire

// ----- hdl/svm_gain_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
module svm_gain_div (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire svm_pkg::gain_req_t  req,
    output logic                     done,
    output logic [13:0]              gain
);
    import svm_pkg::*;

    logic [2:0]  phase_reg;
    logic        done_reg;
    logic [6:0]  vel_reg;
    logic [7:0]  pad_reg;
    logic [7:0]  mv_reg;
    logic [14:0] p1_reg;
    logic [22:0] prod_reg;
    logic [34:0] rem_reg;
    logic [12:0] q_reg;

    // Phases 1 and 2 form the product, phase 3 estimates the quotient by the reciprocal,
    // phase 4 forms the remainder and phase 5 corrects the estimate, which is at most one low.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 3'd0;
            done_reg  <= 1'b0;
        end
        else if (req.load)
        begin
            phase_reg <= 3'd1;
            done_reg  <= 1'b0;
        end
        else if (phase_reg == 3'd5)
        begin
            phase_reg <= 3'd0;
            done_reg  <= 1'b1;
        end
        else if (phase_reg != 3'd0)
        begin
            phase_reg <= phase_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.load)
        begin
            vel_reg <= req.velocity;
            pad_reg <= req.pad_gain;
            mv_reg  <= req.master_volume;
        end
        else
        begin
            case (phase_reg)
                3'd1:
                begin
                    p1_reg <= 15'(vel_reg * pad_reg);
                end
                3'd2:
                begin
                    prod_reg <= 23'(p1_reg * mv_reg);
                end
                3'd3:
                begin
                    q_reg <= 13'((46'(prod_reg) * 46'(GAIN_RECIP)) >> 32);
                end
                3'd4:
                begin
                    rem_reg <= {prod_reg, 12'd0} - 35'(q_reg) * GAIN_DIV;
                end
                3'd5:
                begin
                    if (rem_reg >= GAIN_DIV)
                    begin
                        q_reg <= q_reg + 13'd1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign done = done_reg;
    assign gain = {1'b0, q_reg};

endmodule
`default_nettype wire

// ----- hdl/sample_voice_mixer_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// A load reduces the address modulo the memory size and writes the word; fade-all walks the
// voices once; a trigger walks them for the choke group, scans for a free or the oldest voice
// and waits for the five-step gain unit (it ends after the choke walk when its length is below
// 2); a tick reads and interpolates samples for each playing voice, then forms the result.
// Throughput: one beat at a time, start is taken only while busy is low. Reset: asynchronous,
// active low; voices go inactive, the frame counter clears, master volume returns to 255.
module sample_voice_mixer_top #(
    parameter int VOICES       = 8,
    parameter int SAMPLE_WORDS = 65536
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         req_type,
    input  wire logic [15:0]        mem_address,
    input  wire logic signed [15:0] mem_word,
    input  wire logic [15:0]        sound_length,
    input  wire logic [3:0]         pad_number,
    input  wire logic [6:0]         velocity,
    input  wire logic [7:0]         pad_gain,
    input  wire logic signed [7:0]  pitch_semis,
    input  wire logic [19:0]        base_step,
    input  wire logic [3:0]         choke_group,
    input  wire logic               cfg_we,
    input  wire logic [7:0]         cfg_data,
    output logic                    result_valid,
    output logic signed [15:0]      mixed_sample,
    output logic                    clipped,
    output logic [3:0]              active_count
);
    import svm_pkg::*;

    localparam int VIW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int CW  = $clog2(VOICES + 1);
    localparam int AW  = $clog2(SAMPLE_WORDS);
    localparam int ACW = 21 + VIW;
    // Reciprocal for reducing a 17-bit address modulo the memory size.
    localparam int RECIP = (1 << 24) / SAMPLE_WORDS;
    localparam logic [16:0] RECIP17 = 17'(RECIP);
    localparam logic [17:0] SW18    = 18'(SAMPLE_WORDS);
    localparam logic [VIW-1:0] LAST_V = VIW'(VOICES - 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MOD1  = 4'd1;
    localparam logic [3:0] S_MOD2  = 4'd2;
    localparam logic [3:0] S_MOD3  = 4'd3;
    localparam logic [3:0] S_FADE  = 4'd4;
    localparam logic [3:0] S_CHOKE = 4'd5;
    localparam logic [3:0] S_SCAN  = 4'd6;
    localparam logic [3:0] S_TWAIT = 4'd7;
    localparam logic [3:0] S_VOICE = 4'd8;
    localparam logic [3:0] S_RD1   = 4'd9;
    localparam logic [3:0] S_INTP  = 4'd10;
    localparam logic [3:0] S_SMP   = 4'd11;
    localparam logic [3:0] S_ACC   = 4'd12;
    localparam logic [3:0] S_OUT   = 4'd13;

    // Voice state, one entry per voice, addressed by the walk index or the chosen voice.
    logic              act_reg   [VOICES];
    logic [15:0]       vstart    [VOICES];
    logic [15:0]       vlen      [VOICES];
    logic [32:0]       vpos      [VOICES];
    logic [21:0]       vstep     [VOICES];
    logic [13:0]       vgain     [VOICES];
    logic [12:0]       vfade     [VOICES];
    logic [4:0]        vatt      [VOICES];
    logic [3:0]        vgroup    [VOICES];
    logic [31:0]       vbirth    [VOICES];

    logic [15:0]       mem [SAMPLE_WORDS];
    logic [15:0]       mem_q;
    logic [AW-1:0]     rd_addr;
    logic              mem_we;

    logic [3:0]        state_reg, state_next;
    logic [VIW-1:0]    vidx_reg;
    logic [31:0]       frame_reg;
    logic [7:0]        mv_reg;
    logic              op_load_reg;

    logic [15:0]       addr_reg;
    logic [15:0]       word_reg;
    logic [15:0]       len_reg;
    logic [7:0]        semis_reg;
    logic [19:0]       base_reg;
    logic [3:0]        grp_reg;

    logic [16:0]       x_reg;
    logic [33:0]       mprod_reg;
    logic [17:0]       mrem_reg;
    logic [AW-1:0]     a0_reg;
    logic [AW-1:0]     modres;
    logic [AW-1:0]     a1;

    logic              found_reg;
    logic [VIW-1:0]    free_reg;
    logic [VIW-1:0]    old_pick_reg;
    logic [31:0]       oldest_reg;
    logic [VIW-1:0]    tpick;

    logic signed [15:0] s0_reg;
    logic signed [33:0] iprod_reg;
    logic signed [16:0] sample_reg;
    logic [13:0]        geff_reg;
    logic signed [ACW-1:0] acc_reg;
    logic [CW-1:0]      count_reg;

    logic               res_valid_reg;
    logic signed [15:0] res_sample_reg;
    logic               res_clip_reg;
    logic [3:0]         res_count_reg;

    gain_req_t          greq;
    logic               gain_done;
    logic [13:0]        gain_val;

    logic               accept;
    logic [16:0]        idx;
    logic               release_now;
    logic [12:0]        fade_new;
    logic               fade_end;
    logic signed [4:0]  semis_cl;
    logic [4:0]         ratio_idx;
    logic signed [31:0] term;
    logic signed [16:0] s_diff;
    logic               last_v;
    logic [18:0]        att_prod;

    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE);
    assign last_v = (vidx_reg == LAST_V);

    assign greq.load          = accept && (req_type == REQ_TRIGGER);
    assign greq.velocity      = velocity;
    assign greq.pad_gain      = pad_gain;
    assign greq.master_volume = mv_reg;

    svm_gain_div u_gain (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (greq),
        .done (gain_done),
        .gain (gain_val)
    );

    // Final correction of the reciprocal estimate: the remainder is below twice the size.
    assign modres = AW'((mrem_reg >= SW18) ? (mrem_reg - SW18) : mrem_reg);
    assign a1     = (18'(a0_reg) == SW18 - 18'd1) ? '0 : a0_reg + 1'b1;

    assign idx         = vpos[vidx_reg][32:16];
    assign release_now = (18'(idx) + 18'd1) >= 18'(vlen[vidx_reg]);
    assign fade_new    = ((vgain[vidx_reg] >> FADE_SHIFT) == 14'd0) ? 13'd1
                         : 13'(vgain[vidx_reg] >> FADE_SHIFT);
    assign fade_end    = (vfade[vidx_reg] != 13'd0)
                         && (vgain[vidx_reg] <= 14'(vfade[vidx_reg]));
    assign tpick       = found_reg ? free_reg : old_pick_reg;

    assign semis_cl  = ($signed(semis_reg) < -8'sd12) ? -5'sd12
                       : ($signed(semis_reg) > 8'sd12) ? 5'sd12 : 5'(semis_reg);
    assign ratio_idx = 5'(semis_cl + 5'sd12);

    assign s_diff   = $signed({mem_q[15], mem_q}) - $signed({s0_reg[15], s0_reg});
    assign term     = sample_reg * $signed({1'b0, geff_reg, 1'b0}) >>> 1;
    assign att_prod = vgain[vidx_reg] * (5'(ATTACK_FRAMES) - vatt[vidx_reg]);

    assign rd_addr = (state_reg == S_RD1) ? a1 : modres;
    assign mem_we  = (state_reg == S_MOD3) && op_load_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[modres] <= word_reg;
        end
        mem_q <= mem[rd_addr];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req_type)
                        REQ_LOAD:    state_next = S_MOD1;
                        REQ_TRIGGER: state_next = S_CHOKE;
                        REQ_TICK:    state_next = S_VOICE;
                        default:     state_next = S_FADE;
                    endcase
                end
            end
            S_MOD1:  state_next = S_MOD2;
            S_MOD2:  state_next = S_MOD3;
            S_MOD3:  state_next = op_load_reg ? S_IDLE : S_RD1;
            S_FADE:  state_next = last_v ? S_IDLE : S_FADE;
            S_CHOKE:
            begin
                if (last_v)
                begin
                    state_next = (len_reg < 16'd2) ? S_IDLE : S_SCAN;
                end
            end
            S_SCAN:  state_next = last_v ? S_TWAIT : S_SCAN;
            S_TWAIT: state_next = gain_done ? S_IDLE : S_TWAIT;
            S_VOICE:
            begin
                if (act_reg[vidx_reg] && !release_now)
                begin
                    state_next = S_MOD1;
                end
                else if (last_v)
                begin
                    state_next = S_OUT;
                end
            end
            S_RD1:   state_next = S_INTP;
            S_INTP:  state_next = S_SMP;
            S_SMP:   state_next = S_ACC;
            S_ACC:   state_next = last_v ? S_OUT : S_VOICE;
            S_OUT:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Control state: sequencer, walk index, voice activity, frame counter, volume, result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            vidx_reg      <= '0;
            frame_reg     <= 32'd0;
            mv_reg        <= 8'd255;
            res_valid_reg <= 1'b0;
            op_load_reg   <= 1'b0;
            for (int v = 0; v < VOICES; v++)
            begin
                act_reg[v] <= 1'b0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= (state_reg == S_OUT);
            if (cfg_we)
            begin
                mv_reg <= cfg_data;
            end
            if (accept)
            begin
                op_load_reg <= (req_type == REQ_LOAD);
                vidx_reg    <= '0;
            end
            case (state_reg)
                S_FADE, S_CHOKE, S_SCAN:
                begin
                    vidx_reg <= last_v ? '0 : vidx_reg + 1'b1;
                end
                S_TWAIT:
                begin
                    if (gain_done)
                    begin
                        act_reg[tpick] <= 1'b1;
                    end
                end
                S_VOICE:
                begin
                    if (act_reg[vidx_reg] && release_now)
                    begin
                        act_reg[vidx_reg] <= 1'b0;
                    end
                    if (!(act_reg[vidx_reg] && !release_now) && !last_v)
                    begin
                        vidx_reg <= vidx_reg + 1'b1;
                    end
                end
                S_ACC:
                begin
                    if (fade_end)
                    begin
                        act_reg[vidx_reg] <= 1'b0;
                    end
                    if (!last_v)
                    begin
                        vidx_reg <= vidx_reg + 1'b1;
                    end
                end
                S_OUT:
                begin
                    frame_reg <= frame_reg + 32'd1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            addr_reg  <= mem_address;
            word_reg  <= mem_word;
            len_reg   <= sound_length;
            semis_reg <= pitch_semis;
            base_reg  <= base_step;
            grp_reg   <= choke_group;
            x_reg     <= {1'b0, mem_address};
            found_reg <= 1'b0;
            oldest_reg   <= 32'hFFFF_FFFF;
            old_pick_reg <= '0;
            free_reg     <= '0;
            acc_reg   <= '0;
            count_reg <= '0;
        end
        case (state_reg)
            S_MOD1:
            begin
                mprod_reg <= x_reg * RECIP17;
            end
            S_MOD2:
            begin
                mrem_reg <= 18'(x_reg) - 18'(17'(mprod_reg >> 24) * SW18);
            end
            S_MOD3:
            begin
                a0_reg <= modres;
            end
            S_FADE:
            begin
                if (act_reg[vidx_reg] && vfade[vidx_reg] == 13'd0)
                begin
                    vfade[vidx_reg] <= fade_new;
                end
            end
            S_CHOKE:
            begin
                if (grp_reg != 4'd0 && vgroup[vidx_reg] == grp_reg
                    && act_reg[vidx_reg] && vfade[vidx_reg] == 13'd0)
                begin
                    vfade[vidx_reg] <= fade_new;
                end
            end
            S_SCAN:
            begin
                if (!act_reg[vidx_reg] && !found_reg)
                begin
                    found_reg <= 1'b1;
                    free_reg  <= vidx_reg;
                end
                if (vbirth[vidx_reg] < oldest_reg)
                begin
                    oldest_reg   <= vbirth[vidx_reg];
                    old_pick_reg <= vidx_reg;
                end
            end
            S_TWAIT:
            begin
                if (gain_done)
                begin
                    vstart[tpick] <= addr_reg;
                    vlen[tpick]   <= len_reg;
                    vpos[tpick]   <= 33'd0;
                    vstep[tpick]  <= 22'((38'(base_reg) * pitch_ratio(ratio_idx)) >> 16);
                    vgain[tpick]  <= gain_val;
                    vfade[tpick]  <= 13'd0;
                    vatt[tpick]   <= 5'(ATTACK_FRAMES);
                    vgroup[tpick] <= grp_reg;
                    vbirth[tpick] <= frame_reg;
                end
            end
            S_VOICE:
            begin
                x_reg <= 17'(vstart[vidx_reg]) + idx;
            end
            S_RD1:
            begin
                s0_reg <= mem_q;
            end
            S_INTP:
            begin
                iprod_reg <= s_diff * $signed({1'b0, vpos[vidx_reg][15:0]});
            end
            S_SMP:
            begin
                sample_reg <= 17'($signed({s0_reg[15], s0_reg}) + iprod_reg[32:16]);
                geff_reg   <= (vatt[vidx_reg] != 5'd0) ? 14'(att_prod >> 4) : vgain[vidx_reg];
            end
            S_ACC:
            begin
                acc_reg <= acc_reg + ACW'(term >>> 12);
                vpos[vidx_reg] <= vpos[vidx_reg] + 33'(vstep[vidx_reg]);
                if (vatt[vidx_reg] != 5'd0)
                begin
                    vatt[vidx_reg] <= vatt[vidx_reg] - 5'd1;
                end
                if (vfade[vidx_reg] != 13'd0)
                begin
                    vgain[vidx_reg] <= fade_end ? 14'd0
                                       : vgain[vidx_reg] - 14'(vfade[vidx_reg]);
                end
                if (!fade_end)
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end
            S_OUT:
            begin
                if (acc_reg > ACW'(32767))
                begin
                    res_sample_reg <= 16'sh7FFF;
                    res_clip_reg   <= 1'b1;
                end
                else if (acc_reg < -ACW'(32768))
                begin
                    res_sample_reg <= -16'sh8000;
                    res_clip_reg   <= 1'b1;
                end
                else
                begin
                    res_sample_reg <= 16'(acc_reg);
                    res_clip_reg   <= 1'b0;
                end
                res_count_reg <= 4'(count_reg);
            end
            default:
            begin
            end
        endcase
    end

    assign result_valid = res_valid_reg;
    assign mixed_sample = res_sample_reg;
    assign clipped      = res_clip_reg;
    assign active_count = res_count_reg;

`ifndef SYNTH
    // A frame result is a single beat, never two in a row.
    a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe held for more than one cycle");

    // Results appear only once the sequencer is back at rest.
    a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy)
        else $error("result strobe while busy");

    // An accepted beat always occupies the sequencer.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not start the sequencer");

    // The tally of surviving voices can never exceed the voice count.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT) |-> (32'(count_reg) <= 32'(VOICES)))
        else $error("active voice tally out of range");
`endif

endmodule
`default_nettype wire
